>>> src/vad_pkg.sv
package vad_pkg;

  localparam int unsigned COORD_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned GUARD_BITS       = 20;
  localparam int unsigned ANG_W            = 32;
  localparam int unsigned OUT_W            = 17;
  localparam int unsigned ATAN_LEN         = 32;

  // angles in units of pi/2^31, kept modulo one full turn
  localparam logic [ANG_W-1:0] ANG_ZERO     = 32'h0000_0000;
  localparam logic [ANG_W-1:0] ANG_PI       = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ANG_HALF_PI  = 32'h4000_0000;
  localparam logic [ANG_W-1:0] ANG_MHALF_PI = 32'hC000_0000;
  localparam logic [ANG_W-1:0] ANG_ROUND    = 32'h0000_8000;

  typedef struct packed {
    logic [ANG_W-1:0] z;
    logic             hold;
  } ang_t;

  function automatic logic [ANG_W-1:0] atan_lut(input int unsigned idx);
    logic [ANG_W-1:0] r;
    case (idx)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      20:      r = 32'd652;
      21:      r = 32'd326;
      22:      r = 32'd163;
      23:      r = 32'd81;
      24:      r = 32'd41;
      25:      r = 32'd20;
      26:      r = 32'd10;
      27:      r = 32'd5;
      28:      r = 32'd3;
      29:      r = 32'd1;
      30:      r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/vad_if.sv
interface vad_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;

  modport source (output valid, output a_x, output a_y, output b_x, output b_y, input ready);
  modport sink   (input valid, input a_x, input a_y, input b_x, input b_y, output ready);
endinterface

interface vad_out_if import vad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] angle_diff;

  modport source (output valid, output angle_diff, input ready);
  modport sink   (input valid, input angle_diff, output ready);
endinterface

>>> src/vad_prep.sv
module vad_prep import vad_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned XW          = COORD_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vad_in_if.sink                        in_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [1:0][XW-1:0]     x_o,
  output logic signed [1:0][XW-1:0]     y_o,
  output ang_t        [1:0]             ang_o
);

  logic                      valid_q;
  logic signed [1:0][XW-1:0] x_d, y_d, x_q, y_q;
  ang_t        [1:0]         ang_d, ang_q;
  logic signed [1:0][COORD_WIDTH-1:0] cx, cy;

  assign cx = {in_i.b_x, in_i.a_x};
  assign cy = {in_i.b_y, in_i.a_y};

  always_comb begin
    logic signed [XW-1:0] xe, ye;
    for (int v = 0; v < 2; v++) begin
      xe = XW'($signed(cx[v]));
      ye = XW'($signed(cy[v]));
      ang_d[v].hold = 1'b0;
      ang_d[v].z    = ANG_ZERO;
      x_d[v]        = xe <<< GUARD_BITS;
      y_d[v]        = ye <<< GUARD_BITS;
      if (cy[v] == '0) begin
        // on the x axis the heading is exact, cells leave it alone
        ang_d[v].hold = 1'b1;
        ang_d[v].z    = cx[v][COORD_WIDTH-1] ? ANG_PI : ANG_ZERO;
      end else if (cx[v][COORD_WIDTH-1]) begin
        // left half plane: quarter turn into the right half first
        if (!cy[v][COORD_WIDTH-1]) begin
          x_d[v]     = ye <<< GUARD_BITS;
          y_d[v]     = (-xe) <<< GUARD_BITS;
          ang_d[v].z = ANG_HALF_PI;
        end else begin
          x_d[v]     = (-ye) <<< GUARD_BITS;
          y_d[v]     = xe <<< GUARD_BITS;
          ang_d[v].z = ANG_MHALF_PI;
        end
      end
    end
  end

  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;

endmodule

>>> src/vad_cell.sv
module vad_cell import vad_pkg::*; #(
  parameter int unsigned XW   = COORD_WIDTH_DEF + GUARD_BITS + 3,
  parameter int unsigned STEP = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [1:0][XW-1:0] x_i,
  input  logic signed [1:0][XW-1:0] y_i,
  input  ang_t        [1:0]         ang_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic signed [1:0][XW-1:0] x_o,
  output logic signed [1:0][XW-1:0] y_o,
  output ang_t        [1:0]         ang_o
);

  localparam logic [ANG_W-1:0] Atan = atan_lut(STEP);

  logic                      valid_q;
  logic signed [1:0][XW-1:0] x_d, y_d, x_q, y_q;
  ang_t        [1:0]         ang_d, ang_q;

  always_comb begin
    logic signed [XW-1:0] dx, dy;
    for (int v = 0; v < 2; v++) begin
      // arithmetic shift rounds towards minus infinity
      dx       = $signed(x_i[v]) >>> STEP;
      dy       = $signed(y_i[v]) >>> STEP;
      x_d[v]   = x_i[v];
      y_d[v]   = y_i[v];
      ang_d[v] = ang_i[v];
      if (!ang_i[v].hold) begin
        if ($signed(y_i[v]) > 0) begin
          x_d[v]     = $signed(x_i[v]) + dy;
          y_d[v]     = $signed(y_i[v]) - dx;
          ang_d[v].z = ang_i[v].z + Atan;
        end else begin
          x_d[v]     = $signed(x_i[v]) - dy;
          y_d[v]     = $signed(y_i[v]) + dx;
          ang_d[v].z = ang_i[v].z - Atan;
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ang_q <= ang_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;

endmodule

>>> src/vad_post.sv
module vad_post import vad_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ang_t [1:0]    ang_i,
  vad_out_if.source     out_o
);

  logic                    valid_q;
  logic [ANG_W-1:0]        diff;
  logic [15:0]             turn;
  logic signed [OUT_W-1:0] angle_d, angle_q;

  // only the low turn bits matter after the wrap, so the difference wraps too
  assign diff = ang_i[0].z - ang_i[1].z + ANG_ROUND;
  assign turn = diff[31:16];

  always_comb begin
    if (turn == 16'h8000) begin
      angle_d = 17'sh08000; // minus pi is reported as plus pi
    end else begin
      angle_d = {turn[15], turn};
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      angle_q <= angle_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.angle_diff = angle_q;

endmodule

>>> src/vector_angle_difference.sv
// Signed angle from vector b to vector a, in units of pi/32768 within (-pi, pi].
// Both headings come from a CORDIC vectoring pipeline: one input cell that
// settles the axis cases and turns left half plane vectors by a quarter turn,
// a row of CORDIC_STEPS cells doing one shift-add step each for both vectors,
// and an output cell that subtracts, rounds and wraps. One word is accepted
// every cycle while the output is not stalled. Every cell has its own
// valid register, so a stalled output holds only the cells behind it while
// empty cells further up keep taking words.
module vector_angle_difference import vad_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vad_in_if.sink    in_i,
  vad_out_if.source out_o
);

  localparam int unsigned XW = COORD_WIDTH + GUARD_BITS + 3;

  logic        [CORDIC_STEPS:0]                v_stage, r_stage;
  logic signed [CORDIC_STEPS:0][1:0][XW-1:0]   x_stage, y_stage;
  ang_t        [CORDIC_STEPS:0][1:0]           a_stage;

  vad_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (v_stage[0]),
    .ready_i (r_stage[0]),
    .x_o     (x_stage[0]),
    .y_o     (y_stage[0]),
    .ang_o   (a_stage[0])
  );

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cell
    vad_cell #(
      .XW   (XW),
      .STEP (s)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_stage[s]),
      .ready_o (r_stage[s]),
      .x_i     (x_stage[s]),
      .y_i     (y_stage[s]),
      .ang_i   (a_stage[s]),
      .valid_o (v_stage[s+1]),
      .ready_i (r_stage[s+1]),
      .x_o     (x_stage[s+1]),
      .y_o     (y_stage[s+1]),
      .ang_o   (a_stage[s+1])
    );
  end

  vad_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_stage[CORDIC_STEPS]),
    .ready_o (r_stage[CORDIC_STEPS]),
    .ang_i   (a_stage[CORDIC_STEPS]),
    .out_o   (out_o)
  );

  // a sink that takes words must never hold the input back
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output is ready");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.angle_diff <= 17'sd32768 && out_o.angle_diff >= -17'sd32767))
    else $error("angle difference outside (-pi, pi]");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(v_stage[CORDIC_STEPS]))
    else $error("output word appeared without a word in the last cell");

endmodule
